/* sv/sha512_hash_engine_defines.svh */
// ----------------------------------------------------------------------------
// sha512_hash_engine_defines
// Assertion helper macros for the SHA-512 engine.
// ----------------------------------------------------------------------------
`ifndef SHA512_HASH_ENGINE_DEFINES_SVH
`define SHA512_HASH_ENGINE_DEFINES_SVH
// implication checked every edge outside reset
`define SHA_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");
// next-cycle implication
`define SHA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");
`endif

/* sv/sha_pkg.sv */
// ----------------------------------------------------------------------------
// sha_pkg
// Types, constants and round functions for the SHA-512 engine.
// ----------------------------------------------------------------------------
`default_nettype none
package sha_pkg;
  localparam int QDEPTH = 4;

  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } blkw_t;

  typedef enum logic [2:0] {
    F_IDLE, F_PAD, F_LEN_HI, F_LEN_LO
  } fstate_t;

  typedef enum logic [1:0] {
    B_LOAD, B_ROUND, B_ADD, B_EMIT
  } bstate_t;

  localparam logic [63:0] IV [8] = '{
    64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
    64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
    64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};

  localparam logic [63:0] K [80] = '{
    64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
    64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
    64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
    64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
    64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
    64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
    64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
    64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
    64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
    64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
    64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
    64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
    64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
    64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
    64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
    64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
    64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
    64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
    64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
    64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};

  function automatic logic [63:0] rotr(input logic [63:0] x, input int n);
    rotr = (x >> n) | (x << (64 - n));
  endfunction
endpackage
`default_nettype wire

/* sv/sha_if.sv */
// ----------------------------------------------------------------------------
// sha_in_if / sha_out_if
// Valid/ready channels for message words and digest words.
// ----------------------------------------------------------------------------
`default_nettype none
interface sha_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] message_word;
  logic [3:0]  valid_bytes;
  logic        final_word;
  modport source (output valid, message_word, valid_bytes, final_word, input ready);
  modport sink (input valid, message_word, valid_bytes, final_word, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic [2:0]  digest_index;
  logic        digest_last;
  modport source (output valid, digest_word, digest_index, digest_last, input ready);
  modport sink (input valid, digest_word, digest_index, digest_last, output ready);
endinterface
`default_nettype wire

/* sv/sha_front.sv */
// ----------------------------------------------------------------------------
// sha_front
// Takes message words, counts bytes, inserts the marker, fill and length.
// Emits a stream of block words; last marks the final word of a message.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_front
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sha_in_if.sink     in_ch,
  output blkw_t      bw,
  output logic       bw_valid,
  input  wire logic  bw_ready
);
  fstate_t     state, state_next;
  logic [60:0] byte_total, byte_total_next;
  logic [3:0]  word_slot, word_slot_next;
  logic        need_marker, need_marker_next;
  logic [3:0]  nb;
  logic [63:0] kept, mask;

  always_comb begin
    nb = (in_ch.valid_bytes > 4'd8) ? 4'd8 : in_ch.valid_bytes;
    mask = (nb == 4'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {nb, 3'b000});
    kept = (in_ch.message_word & mask) | (64'h80 << (7'd56 - {nb[2:0], 3'b000}));
  end

  always_comb begin
    state_next = state;
    byte_total_next = byte_total;
    word_slot_next = word_slot;
    need_marker_next = need_marker;
    in_ch.ready = 1'b0;
    bw_valid = 1'b0;
    bw.word = 64'd0;
    bw.last = 1'b0;
    unique case (state)
      F_IDLE: begin
        in_ch.ready = bw_ready;
        bw_valid = in_ch.valid;
        if (!in_ch.final_word || nb == 4'd8) bw.word = in_ch.message_word;
        else bw.word = kept;
        if (in_ch.valid && bw_ready) begin
          word_slot_next = word_slot + 4'd1;
          if (!in_ch.final_word) begin
            byte_total_next = byte_total + 61'd8;
          end else begin
            byte_total_next = byte_total + 61'(nb);
            need_marker_next = (nb == 4'd8);
            state_next = F_PAD;
          end
        end
      end
      F_PAD: begin
        // a full final word still owes the marker word, in any slot
        if (need_marker) begin
          bw_valid = 1'b1;
          bw.word = 64'h8000000000000000;
          if (bw_ready) begin
            need_marker_next = 1'b0;
            word_slot_next = word_slot + 4'd1;
          end
        end else if (word_slot == 4'd14) begin
          state_next = F_LEN_HI;
        end else begin
          bw_valid = 1'b1;
          if (bw_ready) word_slot_next = word_slot + 4'd1;
        end
      end
      F_LEN_HI: begin
        bw_valid = 1'b1;
        if (bw_ready) begin
          word_slot_next = word_slot + 4'd1;
          state_next = F_LEN_LO;
        end
      end
      default: begin
        bw_valid = 1'b1;
        bw.word = {byte_total, 3'b000};
        bw.last = 1'b1;
        if (bw_ready) begin
          word_slot_next = 4'd0;
          byte_total_next = 61'd0;
          state_next = F_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
      byte_total <= 61'd0;
      word_slot <= 4'd0;
      need_marker <= 1'b0;
    end else begin
      state <= state_next;
      byte_total <= byte_total_next;
      word_slot <= word_slot_next;
      need_marker <= need_marker_next;
    end
  end
endmodule
`default_nettype wire

/* sv/sha_queue.sv */
// ----------------------------------------------------------------------------
// sha_queue
// Short FIFO of block words between front and back.
// ----------------------------------------------------------------------------
`default_nettype none
module sha_queue
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire blkw_t wr_data,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  output blkw_t      rd_data,
  output logic       rd_valid,
  input  wire logic  rd_ready
);
  localparam int AW = $clog2(QDEPTH);
  blkw_t         mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0]   cnt;
  logic          push, pop;

  assign wr_ready = (cnt != (AW+1)'(QDEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_data = mem[rp];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0;
      rp <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + 1'b1;
      if (pop) rp <= rp + 1'b1;
      cnt <= cnt + (AW+1)'(push) - (AW+1)'(pop);
    end
  end
endmodule
`default_nettype wire

/* sv/sha_back.sv */
// ----------------------------------------------------------------------------
// sha_back
// Loads 16 block words, runs 80 rounds, folds into the chaining value and
// emits the digest after the final block of a message.
// ----------------------------------------------------------------------------
`default_nettype none
`include "sha512_hash_engine_defines.svh"
module sha_back
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  input  wire blkw_t bw,
  input  wire logic  bw_valid,
  output logic       bw_ready,
  sha_out_if.source  out_ch
);
  bstate_t     state, state_next;
  logic [63:0] hv [8];
  logic [63:0] w [16];
  logic [63:0] a, b, c, d, e, f, g, h;
  logic [6:0]  rnd;
  logic [3:0]  slot;
  logic        msg_last;
  logic [2:0]  oidx;
  logic [63:0] wt, wnew, s0, s1, t1, t2;

  always_comb begin
    s1 = rotr(w[14], 19) ^ rotr(w[14], 61) ^ (w[14] >> 6);
    s0 = rotr(w[1], 1) ^ rotr(w[1], 8) ^ (w[1] >> 7);
    wnew = s1 + w[9] + s0 + w[0];
    wt = w[0];
    t1 = h + (rotr(e, 14) ^ rotr(e, 18) ^ rotr(e, 41)) + ((e & f) ^ (~e & g))
         + K[rnd] + wt;
    t2 = (rotr(a, 28) ^ rotr(a, 34) ^ rotr(a, 39)) + ((a & b) ^ (a & c) ^ (b & c));
  end

  always_comb begin
    state_next = state;
    bw_ready = 1'b0;
    unique case (state)
      B_LOAD: begin
        bw_ready = 1'b1;
        if (bw_valid && slot == 4'd15) state_next = B_ROUND;
      end
      B_ROUND: if (rnd == 7'd79) state_next = B_ADD;
      B_ADD: state_next = msg_last ? B_EMIT : B_LOAD;
      default: if (out_ch.ready && oidx == 3'd7) state_next = B_LOAD;
    endcase
  end

  assign out_ch.valid = (state == B_EMIT);
  assign out_ch.digest_word = hv[oidx];
  assign out_ch.digest_index = oidx;
  assign out_ch.digest_last = (oidx == 3'd7);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // schedule window shifts: w[0] is always the current round word
  always_ff @(posedge clk) begin
    if (state == B_LOAD && bw_valid) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= bw.word;
    end else if (state == B_ROUND) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= wnew;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot <= 4'd0;
      rnd <= 7'd0;
      oidx <= 3'd0;
      msg_last <= 1'b0;
      for (int i = 0; i < 8; i++) hv[i] <= IV[i];
    end else begin
      unique case (state)
        B_LOAD: if (bw_valid) begin
          slot <= slot + 4'd1;
          if (slot == 4'd15) begin
            msg_last <= bw.last;
            rnd <= 7'd0;
          end
        end
        B_ROUND: rnd <= rnd + 7'd1;
        B_ADD: oidx <= 3'd0;
        default: if (out_ch.ready) begin
          oidx <= oidx + 3'd1;
          if (oidx == 3'd7) for (int i = 0; i < 8; i++) hv[i] <= IV[i];
        end
      endcase
      if (state == B_ADD) begin
        hv[0] <= hv[0] + a; hv[1] <= hv[1] + b; hv[2] <= hv[2] + c;
        hv[3] <= hv[3] + d; hv[4] <= hv[4] + e; hv[5] <= hv[5] + f;
        hv[6] <= hv[6] + g; hv[7] <= hv[7] + h;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == B_LOAD) begin
      a <= hv[0]; b <= hv[1]; c <= hv[2]; d <= hv[3];
      e <= hv[4]; f <= hv[5]; g <= hv[6]; h <= hv[7];
    end else if (state == B_ROUND) begin
      a <= t1 + t2; b <= a; c <= b; d <= c;
      e <= d + t1; f <= e; g <= f; h <= g;
    end
  end

  `SHA_ASSERT_IMP(a_round_range, state == B_ROUND, rnd <= 7'd79)
  `SHA_ASSERT_IMP(a_no_take_busy, bw_ready, state == B_LOAD)
  `SHA_ASSERT_NEXT(a_add_after_79, state == B_ROUND && rnd == 7'd79, state == B_ADD)
endmodule
`default_nettype wire

/* sv/sha512_hash_engine.sv */
// SHA-512 engine: each 16-word block is loaded, run through 80 rounds and
// folded into the chaining value; the back end takes no words meanwhile and
// the input stalls while the 4-entry word queue is full. After a final word,
// padding fills the current block and may add one more, then 8 digest words.
// Reset (rst, sync) restores the initial hash value and clears counters.
// ----------------------------------------------------------------------------
// sha512_hash_engine
// Top level: front end, word queue and compression back end.
// ----------------------------------------------------------------------------
`default_nettype none
module sha512_hash_engine
  import sha_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst,
  sha_in_if.sink     in_ch,
  sha_out_if.source  out_ch
);
  blkw_t fw, qw;
  logic  fv, fr, qv, qr;

  sha_front u_front (.clk, .rst, .in_ch, .bw(fw), .bw_valid(fv), .bw_ready(fr));
  sha_queue u_queue (.clk, .rst, .wr_data(fw), .wr_valid(fv), .wr_ready(fr),
                     .rd_data(qw), .rd_valid(qv), .rd_ready(qr));
  sha_back  u_back (.clk, .rst, .bw(qw), .bw_valid(qv), .bw_ready(qr), .out_ch);
endmodule
`default_nettype wire
